@@ rtl/fsd_pkg.sv @@
package fsd_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int CW        = (AW + 1 > 12) ? AW + 1 : 12;

    // Fixed field widths
    localparam int PIX_W = 8;
    localparam int ERR_W = 11;
    localparam int ROW_W = 12;
    localparam int CFG_W = 12;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MAX_GRAY     = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD    = 2'd3;

    typedef logic signed [ERR_W-1:0] t_err;

    // Per-item control carried from the read stage to the diffusion stage
    typedef struct packed {
        logic [AW-1:0] col;
        logic          last_col;
        logic          last_row;
        logic          row0;
    } t_s1_ctl;

    // Clamp a carry sum to the error range
    function automatic t_err sat_err(input logic signed [12:0] x);
        t_err r;
        if (x > 13'sd1023) begin
            r = 11'sd1023;
        end else if (x < -13'sd1024) begin
            r = -11'sd1024;
        end else begin
            r = t_err'(x);
        end
        return r;
    endfunction

    // Divide by 16, rounding toward zero
    function automatic logic signed [11:0] div16_trunc(input logic signed [15:0] x);
        logic signed [15:0] t;
        t = x + (x[15] ? 16'sd15 : 16'sd0);
        return 12'(t >>> 4);
    endfunction

endpackage

@@ rtl/fsd_line_ram.sv @@
module fsd_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fsd_diffuse.sv @@
module fsd_diffuse import fsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_s1_ctl          i_ctl,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_err             i_below,
    input  logic [PIX_W-1:0] i_max_gray,
    input  logic [PIX_W-1:0] i_threshold,
    output logic [PIX_W-1:0] o_quant,
    output t_err             o_left_err,
    output t_err             o_below_err
);

    t_err r_right_err;
    t_err r_below_left;
    t_err r_below_sum;

    logic signed [12:0] below_x;
    logic signed [12:0] v;
    logic signed [12:0] p;
    logic signed [12:0] e;
    logic signed [15:0] e16;
    logic signed [11:0] s7;
    logic signed [11:0] s3;
    logic signed [11:0] s5;
    logic signed [11:0] s1;
    logic               white;

    // Quantize the pixel plus its carried error
    always_comb begin
        below_x = i_ctl.row0 ? 13'sd0 : 13'(i_below);
        v       = $signed({5'b0, i_pixel}) + 13'(r_right_err) + below_x;
        white   = v > $signed({5'b0, i_threshold});
        p       = white ? $signed({5'b0, i_max_gray}) : 13'sd0;
        e       = v - p;
        e16     = 16'(e);
        s7      = div16_trunc((e16 <<< 3) - e16);
        s3      = div16_trunc((e16 <<< 1) + e16);
        s5      = div16_trunc((e16 <<< 2) + e16);
        s1      = div16_trunc(e16);
    end

    // Quantized pixel and the shares landing in the next row
    assign o_quant     = white ? i_max_gray : '0;
    assign o_left_err  = sat_err(13'(r_below_left) + 13'(s3));
    assign o_below_err = sat_err(13'(r_below_sum) + 13'(s5));

    // Advance the carries, clear them at the end of a row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_err  <= '0;
            r_below_left <= '0;
            r_below_sum  <= '0;
        end else if (i_fire) begin
            if (i_ctl.last_col) begin
                r_right_err  <= '0;
                r_below_left <= '0;
                r_below_sum  <= '0;
            end else begin
                r_right_err  <= sat_err(13'(s7));
                r_below_left <= o_below_err;
                r_below_sum  <= sat_err(13'(s1));
            end
        end
    end

endmodule

@@ rtl/floyd_steinberg_dither_stream.sv @@
// Floyd-Steinberg dither on a raster gray stream, one binary pixel per input item.
// An accepted item is held in the read stage (line store read), then diffused into the output register.
// Throughput: 1 item per cycle while the output is not stalled; the carry loop closes in the diffusion stage per item.
// Reset: synchronous, active low; clears counters, error carries, pipeline valids
// and loads register defaults. The line store is not cleared: row 0 ignores what it reads.
module floyd_steinberg_dither_stream import fsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_out_pixel,
    output logic             o_end_of_line,
    output logic             o_end_of_frame,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [11:0]      r_line_width;
    logic [11:0]      r_frame_height;
    logic [PIX_W-1:0] r_max_gray;
    logic [PIX_W-1:0] r_threshold;

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_s1_valid;
    t_s1_ctl          r_s1;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_fwd_hit;
    t_err             r_fwd_data;

    logic             r_pend_valid;
    logic [AW-1:0]    r_pend_addr;
    t_err             r_pend_data;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_eol;
    logic             r_out_eof;

    logic [CW-1:0]    lw_ext;
    logic [AW-1:0]    wm1;
    logic [ROW_W-1:0] hm1;
    logic             in_accept;
    logic             s1_fire;
    t_s1_ctl          n_s1;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_err             ram_wdata;
    logic [ERR_W-1:0] ram_rdata;
    t_err             below;
    logic [PIX_W-1:0] quant;
    t_err             left_err;
    t_err             below_err;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= 12'd1920;
            r_frame_height <= 12'd800;
            r_max_gray     <= 8'd255;
            r_threshold    <= 8'd127;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[11:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[11:0];
                CFG_MAX_GRAY:     r_max_gray     <= i_cfg_data[PIX_W-1:0];
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Last column and last row, with odd sizes clamped
    always_comb begin
        lw_ext = CW'(r_line_width);
        if (lw_ext == '0) begin
            wm1 = '0;
        end else if (lw_ext > CW'(MAX_WIDTH)) begin
            wm1 = AW'(MAX_WIDTH - 1);
        end else begin
            wm1 = AW'(lw_ext - CW'(1));
        end
        hm1 = (r_frame_height == '0) ? '0 : r_frame_height - 12'd1;
    end

    // Handshake between the stages
    assign s1_fire   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s1_fire;
    assign in_accept = i_valid && !o_stall;

    // Position of the incoming item
    always_comb begin
        n_s1.col      = (r_col > wm1) ? wm1 : r_col;
        n_s1.last_col = (n_s1.col == wm1);
        n_s1.last_row = (r_row >= hm1);
        n_s1.row0     = (r_row == '0);
    end

    // Advance column and row counters on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (n_s1.last_col) begin
                r_col <= '0;
                r_row <= n_s1.last_row ? '0 : r_row + 12'd1;
            end else begin
                r_col <= n_s1.col + AW'(1);
            end
        end
    end

    // Write port: lower-left share first, deferred lower share when free
    always_comb begin
        if (s1_fire && r_s1.col != '0) begin
            ram_we    = 1'b1;
            ram_waddr = r_s1.col - AW'(1);
            ram_wdata = left_err;
        end else begin
            ram_we    = r_pend_valid;
            ram_waddr = r_pend_addr;
            ram_wdata = r_pend_data;
        end
    end

    fsd_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (ERR_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_re    (in_accept),
        .i_raddr (n_s1.col),
        .o_rdata (ram_rdata),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata)
    );

    // Hold the item under diffusion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1       <= n_s1;
            r_s1_pixel <= i_pixel;
        end
    end

    // Forward store writes that the registered read missed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_accept) begin
            r_fwd_hit <= ram_we && (ram_waddr == n_s1.col);
        end else if (ram_we && ram_waddr == r_s1.col) begin
            r_fwd_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept || (ram_we && ram_waddr == r_s1.col)) begin
            r_fwd_data <= ram_wdata;
        end
    end

    // Newest value for this column wins
    always_comb begin
        if (r_pend_valid && r_pend_addr == r_s1.col) begin
            below = r_pend_data;
        end else if (r_fwd_hit) begin
            below = r_fwd_data;
        end else begin
            below = t_err'(ram_rdata);
        end
    end

    // Deferred lower share of the last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (s1_fire && r_s1.last_col) begin
            r_pend_valid <= 1'b1;
        end else if (!(s1_fire && r_s1.col != '0)) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.last_col) begin
            r_pend_addr <= r_s1.col;
            r_pend_data <= below_err;
        end
    end

    fsd_diffuse u_diffuse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_ctl       (r_s1),
        .i_pixel     (r_s1_pixel),
        .i_below     (below),
        .i_max_gray  (r_max_gray),
        .i_threshold (r_threshold),
        .o_quant     (quant),
        .o_left_err  (left_err),
        .o_below_err (below_err)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_pixel <= quant;
            r_out_eol   <= r_s1.last_col;
            r_out_eof   <= r_s1.last_col && r_s1.last_row;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_pixel    = r_out_pixel;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_frame = r_out_eof;

    // The deferred write never meets a lower-left write
    a_pend_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !(s1_fire && r_s1.col != '0))
        else $error("deferred line store write contested");

    // A last column always leaves a deferred write behind
    a_pend_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1.last_col) |=> r_pend_valid)
        else $error("lower share of last column lost");

    // Frame end only on a row end
    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_end_of_frame || o_end_of_line))
        else $error("end of frame without end of line");

    // Output is black or white
    a_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_pixel == '0 || o_out_pixel == r_max_gray))
        else $error("output pixel not binary");

endmodule

@@ tb/sv/tb_floyd_steinberg_dither_stream.sv @@
`timescale 1ns / 1ps

module tb_floyd_steinberg_dither_stream;
    import fsd_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 1900;

    // Expected output pixel with its row and frame flags
    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             eol;
        logic             eof;
    } t_dith_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [PIX_W-1:0] o_out_pixel;
    logic             o_end_of_line;
    logic             o_end_of_frame;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_idx = CFG_LINE_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // Register shadow, reset values
    int unsigned cfg_width  = 1920;
    int unsigned cfg_height = 800;
    int unsigned cfg_gray   = 255;
    int unsigned cfg_thresh = 127;

    // Diffusion state of the predictor
    int          line_err [MAX_WIDTH];
    bit          line_done [MAX_WIDTH];
    int          carry_right = 0;
    int          pend_left   = 0;
    int          pend_below  = 0;
    int unsigned col_cnt     = 0;
    int unsigned row_cnt     = 0;

    logic [PIX_W-1:0] gray_q [$];
    t_dith_res        px_expect_q [$];

    int  err_cnt    = 0;
    int  gap_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    int  hold_req   = 0;
    int  hold_ack   = 0;
    int  quiet_cnt  = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    logic [1:0]       reg_order [4] = '{CFG_LINE_WIDTH, CFG_FRAME_HEIGHT,
                                        CFG_MAX_GRAY, CFG_THRESHOLD};
    // directed settings: small frame, widest row, two-pixel rows with height 0,
    // and a threshold of 255 on a frame of all-255 pixels
    logic [CFG_W-1:0] dir_cfg [4][4] = '{'{12'd4, 12'd2, 12'd255, 12'd127},
                                         '{12'd4095, 12'd4095, 12'd0, 12'd255},
                                         '{12'd2, 12'd0, 12'd1, 12'd0},
                                         '{12'd3, 12'd3, 12'd255, 12'd255}};
    int               dir_len [4] = '{8, 3, 4, 9};
    logic [PIX_W-1:0] dir_px [24] = '{8'd0, 8'd255, 8'd127, 8'd128,
                                      8'd1, 8'd254, 8'd255, 8'd0,
                                      8'd255, 8'd255, 8'd0,
                                      8'd1, 8'd0, 8'd255, 8'd1,
                                      8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                      8'd255, 8'd255, 8'd255, 8'd255};

    floyd_steinberg_dither_stream i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_pixel    (o_out_pixel),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp a carry to the 11-bit signed error range
    function automatic int clamp_err(input int x);
        if (x > 1023) begin
            return 1023;
        end
        if (x < -1024) begin
            return -1024;
        end
        return x;
    endfunction

    // Quantize one pixel and diffuse its error; returns the expected output item
    function automatic t_dith_res dither_pixel(input logic [PIX_W-1:0] px);
        int unsigned w, h, c;
        int          below, v, q, e, s7, s3, s5, s1, nb;
        bit          lc, lr;
        t_dith_res   r;
        w = cfg_width;
        h = cfg_height;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        // a count at or past a shrunken end counts as the last one
        c = col_cnt;
        if (c > w - 1) c = w - 1;
        lc = (c == w - 1);
        lr = (row_cnt >= h - 1);

        below = (row_cnt == 0) ? 0 : line_err[c];
        v = int'(px) + carry_right + below;
        q = (v > int'(cfg_thresh)) ? int'(cfg_gray) : 0;
        e = v - q;
        // shares truncate toward zero
        s7 = (e * 7) / 16;
        s3 = (e * 3) / 16;
        s5 = (e * 5) / 16;
        s1 = e / 16;

        // drop the lower-left share at column 0
        if (c > 0) begin
            line_err[c - 1]  = clamp_err(pend_left + s3);
            line_done[c - 1] = 1'b1;
        end
        nb = clamp_err(pend_below + s5);

        if (lc) begin
            // drop right and lower-right shares, clear carries at row end
            line_err[c]  = nb;
            line_done[c] = 1'b1;
            carry_right  = 0;
            pend_left    = 0;
            pend_below   = 0;
            col_cnt      = 0;
            row_cnt      = lr ? 0 : row_cnt + 1;
        end else begin
            carry_right = clamp_err(s7);
            pend_left   = nb;
            pend_below  = clamp_err(s1);
            col_cnt     = c + 1;
        end

        r.gray = q[PIX_W-1:0];
        r.eol  = lc;
        r.eof  = lc && lr;
        return r;
    endfunction

    // A new width must not make the current or next row read unwritten store entries
    function automatic bit width_safe(input int unsigned raw);
        int unsigned w;
        w = raw;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (row_cnt == 0) begin
            return 1'b1;
        end
        for (int k = 0; k < w; k++) begin
            if (!line_done[k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Write one register while the block is idle and mirror it in the shadow
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LINE_WIDTH:   cfg_width  = val;
            CFG_FRAME_HEIGHT: cfg_height = val;
            CFG_MAX_GRAY:     cfg_gray   = val[PIX_W-1:0];
            CFG_THRESHOLD:    cfg_thresh = val[PIX_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued pixel is taken and every output has come back
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (gray_q.size() != 0 || i_valid || px_expect_q.size() != 0);
    endtask

    // Sender: hold a stalled item, otherwise idle in bursts or offer the next pixel
    always @(posedge i_clk) begin : drive_proc
        logic v_n;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                px_expect_q.push_back(dither_pixel(i_pixel));
            end
            v_n = i_valid && o_stall;
            if (!v_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (gray_q.size() > 0) begin
                    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(1, 9) - 1;
                    end else begin
                        i_pixel <= gray_q.pop_front();
                        v_n = 1'b1;
                    end
                end
            end
            i_valid <= v_n;
        end
    end

    // Receiver: check each accepted item, then pick the next stall value
    always @(posedge i_clk) begin : sink_proc
        t_dith_res want;
        logic      s_n;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (px_expect_q.size() == 0) begin
                    $error("unexpected output item: out_pixel %0d", o_out_pixel);
                    err_cnt++;
                end else begin
                    want = px_expect_q.pop_front();
                    if (o_out_pixel !== want.gray) begin
                        $error("out_pixel: expected %0d, got %0d", want.gray, o_out_pixel);
                        err_cnt++;
                    end
                    if (o_end_of_line !== want.eol) begin
                        $error("end_of_line: expected %0d, got %0d", want.eol, o_end_of_line);
                        err_cnt++;
                    end
                    if (o_end_of_frame !== want.eof) begin
                        $error("end_of_frame: expected %0d, got %0d",
                               want.eof, o_end_of_frame);
                        err_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                s_n = 1'b1;
            end else if (hold_req != hold_ack) begin
                // long hold-off so the block backs up into its input
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES - 1;
                s_n = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                s_n = 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                s_n = 1'b1;
            end else begin
                s_n = 1'b0;
            end
            i_stall <= s_n;
        end
    end

    // End the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cnt <= 0;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
        if (quiet_cnt == STALL_LIMIT) begin
            $display("tb_floyd_steinberg_dither_stream: errors");
            $finish;
        end
    end

    initial begin : stim_proc
        int               n_sent;
        int               n_phase;
        int               pos;
        int               mode;
        int               len;
        int               t;
        int unsigned      w;
        logic [PIX_W-1:0] g;
        bit               quiet;

        n_sent  = 0;
        n_phase = 0;
        pos     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (int p = 0; p < 4; p++) begin
            for (int r = 0; r < 4; r++) begin
                write_reg(reg_order[r], dir_cfg[p][r]);
            end
            for (int k = 0; k < dir_len[p]; k++) begin
                gray_q.push_back(dir_px[pos]);
                pos++;
            end
            n_sent += dir_len[p];
            wait_drained();
        end

        // random phases; quiet at the end
        while (n_sent < ITEM_TARGET) begin
            quiet      = (n_sent > ITEM_TARGET - 250);
            tx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
            rx_idle_on = !quiet && ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0:       w = 0;
                    1:       w = 1;
                    2:       w = 2;
                    3:       w = 4095;
                    4:       w = MAX_WIDTH;
                    5:       w = $urandom_range(MAX_WIDTH + 1, 4095);
                    default: w = $urandom_range(2, 16);
                endcase
                if (width_safe(w)) begin
                    write_reg(CFG_LINE_WIDTH, w[CFG_W-1:0]);
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       t = 0;
                    1:       t = 1;
                    2:       t = 4095;
                    3:       t = $urandom_range(1, 4095);
                    default: t = $urandom_range(2, 6);
                endcase
                write_reg(CFG_FRAME_HEIGHT, t[CFG_W-1:0]);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       t = 0;
                    1:       t = 1;
                    2:       t = 255;
                    default: t = $urandom_range(0, 255);
                endcase
                write_reg(CFG_MAX_GRAY, {4'($urandom_range(0, 15)), t[PIX_W-1:0]});
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       t = 0;
                    1:       t = 255;
                    2:       t = 127;
                    default: t = $urandom_range(0, 255);
                endcase
                write_reg(CFG_THRESHOLD, {4'($urandom_range(0, 15)), t[PIX_W-1:0]});
            end

            // pick pixel content: uniform, extremes, near threshold, or a ramp
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 120);
            if (n_phase == 4) begin
                tx_idle_on = 1'b0;
                len = 120;
            end
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: g = $urandom_range(0, 255);
                    1: begin
                        case ($urandom_range(0, 3))
                            0:       g = 8'd0;
                            1:       g = 8'd255;
                            2:       g = 8'd1;
                            default: g = 8'd254;
                        endcase
                    end
                    2: begin
                        t = int'(cfg_thresh) + int'($urandom_range(0, 6)) - 3;
                        if (t < 0) t = 0;
                        if (t > 255) t = 255;
                        g = t[PIX_W-1:0];
                    end
                    default: g = PIX_W'(k * 9 + n_phase);
                endcase
                gray_q.push_back(g);
            end
            n_sent += len;
            if (n_phase == 4) begin
                hold_req++;
            end
            n_phase++;
            wait_drained();
        end

        // let any stray output show up before the verdict
        repeat (8) @(posedge i_clk);
        if (px_expect_q.size() != 0) begin
            $error("%0d expected output items never arrived", px_expect_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb_floyd_steinberg_dither_stream: clean");
        end else begin
            $display("tb_floyd_steinberg_dither_stream: errors");
        end
        $finish;
    end

endmodule
